FILE: rtl/afe_pkg.sv
package afe_pkg;

    localparam int unsigned CNT_W       = 7;
    localparam int unsigned IDX_W       = 4;
    localparam logic [CNT_W-1:0] MAX_PAYLOAD = 7'd100;

    localparam logic [7:0] BYTE_DELIM = 8'h7E;
    localparam logic [7:0] BYTE_ESC   = 8'h7D;
    localparam logic [7:0] BYTE_XON   = 8'h11;
    localparam logic [7:0] BYTE_XOFF  = 8'h13;
    localparam logic [7:0] BYTE_FLIP  = 8'h20;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_OPT   = 8'h01;
    localparam logic [7:0] BYTE_CKSUM = 8'hFF;
    localparam logic [7:0] API_ID16   = 8'h01;
    localparam logic [7:0] API_ID64   = 8'h00;

    localparam logic [15:0] HDR_LEN16 = 16'd5;
    localparam logic [15:0] HDR_LEN64 = 16'd11;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // step indexes of a start request
    localparam logic [IDX_W-1:0] IDX_DELIM  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_LEN_HI = 4'd1;
    localparam logic [IDX_W-1:0] IDX_LEN_LO = 4'd2;
    localparam logic [IDX_W-1:0] IDX_ID     = 4'd3;
    localparam logic [IDX_W-1:0] IDX_FID    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_ADDR   = 4'd5;
    localparam logic [IDX_W-1:0] IDX_ADDR_LAST16 = 4'd6;
    localparam logic [IDX_W-1:0] IDX_ADDR_LAST64 = 4'd12;

    typedef struct packed {
        logic        func;
        logic        addr_mode;
        logic [63:0] dest_addr;
        logic [15:0] payload_count;
        logic [7:0]  payload_byte;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       fend;
    } t_emit;

    function automatic logic is_special(input logic [7:0] b);
        is_special = (b == BYTE_DELIM) || (b == BYTE_ESC) ||
                     (b == BYTE_XON) || (b == BYTE_XOFF);
    endfunction

endpackage

FILE: rtl/api_frame_escaper_tx.sv
// Escaped API transmit frame builder. A start request (func 0) emits the 0x7E
// delimiter, the two-byte length, the API header and, for a zero count, the
// checksum; each payload request (func 1) emits its byte and, after the last
// one, the checksum. Header, payload and checksum bytes are escaped (0x7D,
// byte ^ 0x20); a payload request while no frame is open is dropped. One
// request is held in an input register and walked by a step sequencer that
// writes one line byte per cycle into the output register whenever that
// register can take one. A payload request makes one or two line bytes plus
// up to two more for the checksum after the last one; a start request makes
// up to 24. A dropped payload request is released with no byte written. A
// new request is taken in the cycle its predecessor's last byte is written.
module api_frame_escaper_tx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic        i_addr_mode,
    input  logic [63:0] i_dest_addr,
    input  logic [15:0] i_payload_count,
    input  logic [7:0]  i_payload_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_frame_end
);

    afe_pkg::t_item in_item;
    afe_pkg::t_item held_item;
    afe_pkg::t_emit emit;
    logic           held_valid;
    logic           release_item;
    logic           load_ok;

    always_comb begin
        in_item.func          = i_func;
        in_item.addr_mode     = i_addr_mode;
        in_item.dest_addr     = i_dest_addr;
        in_item.payload_count = i_payload_count;
        in_item.payload_byte  = i_payload_byte;
    end

    afe_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_release    (release_item),
        .o_item_valid (held_valid),
        .o_item       (held_item)
    );

    afe_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_load_ok    (load_ok),
        .o_release    (release_item),
        .o_emit       (emit)
    );

    afe_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_load_ok   (load_ok),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule

FILE: rtl/afe_in_reg.sv
module afe_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  afe_pkg::t_item i_item,
    input  logic          i_release,
    output logic          o_item_valid,
    output afe_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    afe_pkg::t_item r_item;
    afe_pkg::t_item n_item;
    logic           take;

    assign o_ready      = !r_valid || i_release;
    assign take         = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (take) begin
            n_valid = 1'b1;
            n_item  = i_item;
        end else if (i_release) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

FILE: rtl/afe_step.sv
module afe_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  afe_pkg::t_item i_item,
    input  logic           i_load_ok,
    output logic           o_release,
    output afe_pkg::t_emit o_emit
);

    logic [afe_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_esc, n_esc;
    logic                      r_active, n_active;
    logic [afe_pkg::CNT_W-1:0] r_left, n_left;
    logic [7:0]                r_sum, n_sum;

    logic [afe_pkg::CNT_W-1:0] cnt_sat;
    logic [afe_pkg::CNT_W-1:0] left_dec;
    logic [15:0]               len;
    logic [afe_pkg::IDX_W-1:0] addr_last;
    logic [2:0]                k;
    logic [2:0]                bsel;
    logic [7:0]                addr_byte;
    logic [7:0]                cksum;
    logic [7:0]                cur;
    logic                      is_data;
    logic                      is_ck;
    logic                      is_last;
    logic                      is_open;
    logic                      drop;
    logic                      prefix;
    logic                      fire;
    logic                      done;

    always_comb begin
        cnt_sat = (i_item.payload_count > 16'(afe_pkg::MAX_PAYLOAD)) ?
                  afe_pkg::MAX_PAYLOAD : i_item.payload_count[afe_pkg::CNT_W-1:0];
        left_dec = r_left - 1'b1;
        len = 16'(cnt_sat) + (i_item.addr_mode ? afe_pkg::HDR_LEN64 : afe_pkg::HDR_LEN16);
        addr_last = i_item.addr_mode ? afe_pkg::IDX_ADDR_LAST64 : afe_pkg::IDX_ADDR_LAST16;
        k = 3'(r_idx - afe_pkg::IDX_ADDR);
        bsel = i_item.addr_mode ? (3'd7 - k) : {2'b00, ~k[0]};
        addr_byte = i_item.dest_addr[{bsel, 3'b000} +: 8];
        cksum = afe_pkg::BYTE_CKSUM - r_sum;

        cur     = afe_pkg::BYTE_ZERO;
        is_data = 1'b0;
        is_ck   = 1'b0;
        is_last = 1'b0;
        is_open = 1'b0;
        drop    = 1'b0;

        if (i_item.func == afe_pkg::FUNC_START) begin
            if (r_idx == afe_pkg::IDX_DELIM) begin
                cur     = afe_pkg::BYTE_DELIM;
                is_open = 1'b1;
            end else if (r_idx == afe_pkg::IDX_LEN_HI) begin
                cur = len[15:8];
            end else if (r_idx == afe_pkg::IDX_LEN_LO) begin
                cur = len[7:0];
            end else if (r_idx == afe_pkg::IDX_ID) begin
                cur     = i_item.addr_mode ? afe_pkg::API_ID64 : afe_pkg::API_ID16;
                is_data = 1'b1;
            end else if (r_idx == afe_pkg::IDX_FID) begin
                cur     = afe_pkg::BYTE_ZERO;
                is_data = 1'b1;
            end else if (r_idx <= addr_last) begin
                cur     = addr_byte;
                is_data = 1'b1;
            end else if (r_idx == addr_last + 1'b1) begin
                cur     = afe_pkg::BYTE_OPT;
                is_data = 1'b1;
                is_last = (cnt_sat != '0);
            end else begin
                cur     = cksum;
                is_ck   = 1'b1;
                is_last = 1'b1;
            end
        end else begin
            drop = !r_active;
            if (r_idx == afe_pkg::IDX_DELIM) begin
                cur     = i_item.payload_byte;
                is_data = 1'b1;
                is_last = (left_dec != '0);
            end else begin
                cur     = cksum;
                is_ck   = 1'b1;
                is_last = 1'b1;
            end
        end

        prefix = (is_data || is_ck) && afe_pkg::is_special(cur) && !r_esc;
        fire   = i_item_valid && !drop && i_load_ok;
        done   = fire && !prefix && is_last;

        o_emit.valid = fire;
        o_emit.data  = prefix ? afe_pkg::BYTE_ESC :
                       (r_esc ? (cur ^ afe_pkg::BYTE_FLIP) : cur);
        o_emit.last  = !prefix && is_last;
        o_emit.fend  = !prefix && is_ck;
        o_release    = i_item_valid && (drop || done);

        n_idx    = r_idx;
        n_esc    = r_esc;
        n_active = r_active;
        n_left   = r_left;
        n_sum    = r_sum;
        if (fire) begin
            if (prefix) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                n_idx = is_last ? '0 : r_idx + 1'b1;
                if (is_open) begin
                    n_active = 1'b1;
                    n_left   = cnt_sat;
                    n_sum    = '0;
                end
                if (is_data) begin
                    n_sum = r_sum + cur;
                end
                if (is_data && i_item.func == afe_pkg::FUNC_PAYLOAD) begin
                    n_left = left_dec;
                end
                if (is_ck) begin
                    n_active = 1'b0;
                    n_left   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_esc    <= 1'b0;
            r_active <= 1'b0;
            r_left   <= '0;
            r_sum    <= '0;
        end else begin
            r_idx    <= n_idx;
            r_esc    <= n_esc;
            r_active <= n_active;
            r_left   <= n_left;
            r_sum    <= n_sum;
        end
    end

endmodule

FILE: rtl/afe_out_reg.sv
module afe_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  afe_pkg::t_emit i_emit,
    output logic           o_load_ok,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_frame_end
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_fend, n_fend;

    assign o_load_ok   = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_last  = r_last;
    assign o_frame_end = r_fend;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_fend  = r_fend;
        if (i_emit.valid) begin
            n_valid = 1'b1;
            n_byte  = i_emit.data;
            n_last  = i_emit.last;
            n_fend  = i_emit.fend;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_byte <= n_byte;
        r_last <= n_last;
        r_fend <= n_fend;
    end

endmodule

FILE: tb/tb.sv
module tb;

    localparam int unsigned STUCK_LIMIT    = 4000;
    localparam int unsigned RX_HOLD_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned PHASE_COUNT    = 4;

    class line_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
            logic       fend;
        } t_line_byte;

        t_line_byte                line_q[$];
        bit                        active;
        logic [afe_pkg::CNT_W-1:0] left;
        logic [7:0]                sum;
        int unsigned               errors;

        function new();
            active = 1'b0;
            left   = '0;
            sum    = '0;
            errors = 0;
        endfunction

        function void push_raw(logic [7:0] data, logic fend);
            t_line_byte entry;
            entry.data = data;
            entry.last = 1'b0;
            entry.fend = fend;
            line_q.push_back(entry);
        endfunction

        function void push_escaped(logic [7:0] data, logic fend);
            if (data == afe_pkg::BYTE_DELIM || data == afe_pkg::BYTE_ESC ||
                data == afe_pkg::BYTE_XON || data == afe_pkg::BYTE_XOFF) begin
                push_raw(afe_pkg::BYTE_ESC, 1'b0);
                push_raw(data ^ afe_pkg::BYTE_FLIP, fend);
            end else begin
                push_raw(data, fend);
            end
        endfunction

        function void push_data(logic [7:0] data);
            sum = sum + data;
            push_escaped(data, 1'b0);
        endfunction

        function void close_frame();
            push_escaped(afe_pkg::BYTE_CKSUM - sum, 1'b1);
            active = 1'b0;
            left   = '0;
        endfunction

        function void note_request(logic func, logic mode, logic [63:0] addr,
                                   logic [15:0] count, logic [7:0] pb);
            t_line_byte                tail;
            int unsigned               first;
            logic [afe_pkg::CNT_W-1:0] n;
            logic [15:0]               len;
            first = line_q.size();
            if (func == afe_pkg::FUNC_START) begin
                n   = (count > afe_pkg::MAX_PAYLOAD) ? afe_pkg::MAX_PAYLOAD :
                      count[afe_pkg::CNT_W-1:0];
                len = {{(16-afe_pkg::CNT_W){1'b0}}, n} +
                      (mode ? afe_pkg::HDR_LEN64 : afe_pkg::HDR_LEN16);
                sum = '0;
                push_raw(afe_pkg::BYTE_DELIM, 1'b0);
                push_raw(len[15:8], 1'b0);
                push_raw(len[7:0], 1'b0);
                push_data(mode ? afe_pkg::API_ID64 : afe_pkg::API_ID16);
                push_data(afe_pkg::BYTE_ZERO);
                if (mode) begin
                    for (int i = 7; i >= 0; i--)
                        push_data(addr[8*i +: 8]);
                end else begin
                    push_data(addr[15:8]);
                    push_data(addr[7:0]);
                end
                push_data(afe_pkg::BYTE_OPT);
                left   = n;
                active = 1'b1;
                if (left == 0)
                    close_frame();
            end else if (active) begin
                push_data(pb);
                left = left - 1'b1;
                if (left == 0)
                    close_frame();
            end
            if (line_q.size() > first) begin
                tail      = line_q.pop_back();
                tail.last = 1'b1;
                line_q.push_back(tail);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_line_byte(logic [7:0] data, logic last, logic fend);
            t_line_byte want;
            if (line_q.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b end %0b",
                                 data, last, fend));
                return;
            end
            want = line_q.pop_front();
            if (want.data !== data || want.last !== last || want.fend !== fend)
                report($sformatf("got %02h/%0b/%0b, want %02h/%0b/%0b",
                                 data, last, fend, want.data, want.last, want.fend));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic        i_addr_mode;
    logic [63:0] i_dest_addr;
    logic [15:0] i_payload_count;
    logic [7:0]  i_payload_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_frame_end;

    line_scoreboard sb = new();

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned requests_sent = 0;
    bit          rx_hold_req   = 1'b0;
    bit          sat_done      = 1'b0;

    int unsigned idle_plan  [PHASE_COUNT] = '{0, 84, 0, 10};
    int unsigned stall_plan [PHASE_COUNT] = '{0, 0, 84, 10};
    int unsigned phase_end  [PHASE_COUNT] = '{130, 240, 350, 460};
    logic [7:0]  specials   [4] = '{afe_pkg::BYTE_DELIM, afe_pkg::BYTE_ESC,
                                    afe_pkg::BYTE_XON, afe_pkg::BYTE_XOFF};

    api_frame_escaper_tx uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_addr_mode     (i_addr_mode),
        .i_dest_addr     (i_dest_addr),
        .i_payload_count (i_payload_count),
        .i_payload_byte  (i_payload_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_frame_end     (o_frame_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(99) < 30)
            return specials[$urandom_range(3)];
        return 8'($urandom_range(255));
    endfunction

    task automatic send_request(input logic func, input logic mode,
                                input logic [63:0] addr, input logic [15:0] count,
                                input logic [7:0] pb);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= func;
        i_addr_mode     <= mode;
        i_dest_addr     <= addr;
        i_payload_count <= count;
        i_payload_byte  <= pb;
        do @(posedge i_clk); while (!o_ready);
        if (func == afe_pkg::FUNC_START || sb.active)
            requests_sent++;
        sb.note_request(func, mode, addr, count, pb);
    endtask

    task automatic directed_frames();
        send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0, 8'hFF);
        send_request(afe_pkg::FUNC_START, 1'b0, '0, '0, 8'h00);
        send_request(afe_pkg::FUNC_START, 1'b1, '1, '0, 8'hFF);
        send_request(afe_pkg::FUNC_START, 1'b0, 64'hFFFF_FFFF_FFFF_7E7D, 16'd4, 8'h00);
        foreach (specials[k])
            send_request(afe_pkg::FUNC_PAYLOAD, 1'b1, '1, '1, specials[k]);
        send_request(afe_pkg::FUNC_START, 1'b1, 64'h7E7D_1113_00FF_2011, 16'd2, 8'h00);
        send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0, 8'h00);
        send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0, 8'hFF);
        // abandoned frame, then a frame whose checksum needs escaping
        send_request(afe_pkg::FUNC_START, 1'b0, 64'h0000_0000_0000_1113, 16'd3, 8'h00);
        send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0, 8'h55);
        send_request(afe_pkg::FUNC_START, 1'b1, 64'h0123_4567_89AB_CDEF, 16'd1, 8'h00);
        send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0,
                     afe_pkg::BYTE_CKSUM - afe_pkg::BYTE_DELIM - sb.sum);
        send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0, afe_pkg::BYTE_DELIM);
    endtask

    task automatic random_frame();
        logic        mode;
        logic [63:0] addr;
        logic [15:0] count;
        logic [7:0]  data;
        int unsigned sel;
        int unsigned n;
        int unsigned full;
        mode = 1'($urandom_range(1));
        for (int i = 0; i < 8; i++)
            addr[8*i +: 8] = rand_byte();
        sel = $urandom_range(99);
        if (sel < 6) begin
            send_request(afe_pkg::FUNC_PAYLOAD, mode, addr,
                         16'($urandom_range(65535)), rand_byte());
            return;
        end
        sel = $urandom_range(99);
        if (sel < 8)
            count = 16'($urandom_range(65535));
        else if (sel < 16)
            count = '0;
        else if (sel < 20)
            count = 16'(afe_pkg::MAX_PAYLOAD) + 16'($urandom_range(3));
        else
            count = 16'($urandom_range(12, 1));
        full = (count > afe_pkg::MAX_PAYLOAD) ? afe_pkg::MAX_PAYLOAD : count;
        n    = full;
        if (count > 12) begin
            if (!sat_done && count > afe_pkg::MAX_PAYLOAD)
                sat_done = 1'b1;
            else
                n = $urandom_range(6);
        end else if (n > 0 && $urandom_range(9) == 0) begin
            n = $urandom_range(n - 1);
        end
        send_request(afe_pkg::FUNC_START, mode, addr, count, 8'($urandom_range(255)));
        for (int i = 0; i < n; i++) begin
            data = rand_byte();
            // steer the checksum onto a byte that must be escaped
            if (i == n - 1 && n == full && $urandom_range(2) == 0)
                data = afe_pkg::BYTE_CKSUM - specials[$urandom_range(3)] - sb.sum;
            send_request(afe_pkg::FUNC_PAYLOAD, 1'($urandom_range(1)),
                         {$urandom, $urandom}, 16'($urandom_range(65535)), data);
        end
        if (n == full && $urandom_range(9) == 0)
            send_request(afe_pkg::FUNC_PAYLOAD, 1'b0, '0, '0, rand_byte());
    endtask

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_line_byte(o_out_byte, o_run_last, o_frame_end);
    end

    initial begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("api_frame_escaper_tx regression: fail");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_func          <= afe_pkg::FUNC_START;
        i_addr_mode     <= 1'b0;
        i_dest_addr     <= '0;
        i_payload_count <= '0;
        i_payload_byte  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_frames();
        for (int p = 0; p < PHASE_COUNT; p++) begin
            tx_idle_pct  = idle_plan[p];
            rx_stall_pct = stall_plan[p];
            if (p == 0)
                rx_hold_req = 1'b1;
            while (requests_sent < phase_end[p])
                random_frame();
        end
        i_valid <= 1'b0;
        while (sb.line_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("api_frame_escaper_tx regression: pass");
        else
            $display("api_frame_escaper_tx regression: fail");
        $finish;
    end
endmodule
